/* rtl/buffer_pool_frame_manager_defines.svh */
// ----------------------------------------------------------------------------
// Buffer pool frame manager assertion macros
// Shared concurrent assertion forms used by the RTL of the frame manager.
// ----------------------------------------------------------------------------
`ifndef BUFFER_POOL_FRAME_MANAGER_DEFINES_SVH
`define BUFFER_POOL_FRAME_MANAGER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bpfm_pkg.sv */
// ----------------------------------------------------------------------------
// Buffer pool frame manager package
// Request and result types, status and opcode codes, cell command type.
// ----------------------------------------------------------------------------
package bpfm_pkg;

  localparam int FRAMES_DEF = 16;
  localparam int CFG_W      = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  localparam logic [7:0] PINS_MAX = 8'hFF;

  localparam logic [1:0] OP_GET     = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_FLUSH   = 2'd2;

  localparam logic [2:0] ST_HIT        = 3'd0;
  localparam logic [2:0] ST_MISS       = 3'd1;
  localparam logic [2:0] ST_NO_FRAME   = 3'd2;
  localparam logic [2:0] ST_RELEASED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [2:0] ST_WRITEBACK  = 3'd5;
  localparam logic [2:0] ST_FLUSH_DONE = 3'd6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  file_number;
    logic [15:0] page_number;
    logic        mark_dirty;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame_index;
    logic        writeback_valid;
    logic [7:0]  writeback_file;
    logic [15:0] writeback_page;
    logic        last;
  } rsp_t;

  // Contents of one frame as held in a cell (recency rank travels beside it).
  typedef struct packed {
    logic        valid;
    logic [7:0]  file_tag;
    logic [15:0] page_tag;
    logic [7:0]  pins;
    logic        dirty;
  } frame_t;

  typedef enum logic [2:0] {
    CELL_NONE,
    CELL_HIT,
    CELL_LOAD,
    CELL_RELEASE,
    CELL_CLEAR
  } cell_op_t;

  // Command broadcast to every cell of the ring.
  typedef struct packed {
    logic        shift;
    cell_op_t    op;
    logic [7:0]  file_tag;
    logic [15:0] page_tag;
    logic        dirty;
  } cell_cmd_t;

endpackage

/* rtl/buffer_pool_frame_manager.sv */
// ----------------------------------------------------------------------------
// Buffer pool frame manager
// Frame table of a database buffer pool with true LRU replacement, built as
// a ring of frame cells scanned one frame a cycle.
// ----------------------------------------------------------------------------
//
//   channel   handshake                   payload           direction
//   --------  --------------------------  ----------------  ---------
//   request   start & !busy               req   (req_t)     in
//   result    result_valid (strobe)       result (rsp_t)    out
//   config    cfg_valid & cfg_ready       cfg_data (5 bit)  in
//
// From acceptance to the next acceptance, a request runs one pass (S_SCAN)
// that rotates the cell ring past the head, where the controller checks
// tags, empty frames and the LRU victim; then S_FINISH broadcasts the
// update and reports the final result. A flush emits its write-backs during
// the pass, at most one a cycle, in ascending frame order.
// Reset (rst, synchronous) empties every frame and sets ranks to frame index.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module buffer_pool_frame_manager #(
  parameter int FRAMES = bpfm_pkg::FRAMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  bpfm_pkg::req_t             req,
  output logic                       result_valid,
  output bpfm_pkg::rsp_t             result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bpfm_pkg::CFG_W-1:0] cfg_data
);
  import bpfm_pkg::*;

  localparam int IDX_W = $clog2(FRAMES);

  // Ring of frames: cell i takes cell i+1's contents on a shift, so during a
  // pass the head (cell 0) shows frame k while the scan count is k.
  frame_t           frames [FRAMES];
  logic [IDX_W-1:0] ranks  [FRAMES];

  cell_cmd_t        cmd;
  logic [IDX_W-1:0] tgt;
  logic [IDX_W-1:0] old_rank;

  bpfm_ctrl #(
    .FRAMES (FRAMES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .head         (frames[0]),
    .head_rank    (ranks[0]),
    .cmd          (cmd),
    .tgt          (tgt),
    .old_rank     (old_rank)
  );

  // Build the ring; the last cell wraps to the head.
  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    bpfm_cell #(
      .FRAMES (FRAMES),
      .POS    (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .tgt       (tgt),
      .old_rank  (old_rank),
      .nbr_frame (frames[(i + 1) % FRAMES]),
      .nbr_rank  (ranks[(i + 1) % FRAMES]),
      .frame     (frames[i]),
      .rank      (ranks[i])
    );
  end

endmodule

/* rtl/bpfm_cell.sv */
// ----------------------------------------------------------------------------
// Frame cell
// Holds one frame of the table; shifts toward the ring head or applies a
// broadcast update when the ring is aligned.
// ----------------------------------------------------------------------------
module bpfm_cell #(
  parameter int FRAMES = bpfm_pkg::FRAMES_DEF,
  parameter int POS    = 0,
  localparam int IDX_W = $clog2(FRAMES)
) (
  input  logic               clk,
  input  logic               rst,
  input  bpfm_pkg::cell_cmd_t cmd,
  input  logic [IDX_W-1:0]   tgt,
  input  logic [IDX_W-1:0]   old_rank,
  input  bpfm_pkg::frame_t   nbr_frame,
  input  logic [IDX_W-1:0]   nbr_rank,
  output bpfm_pkg::frame_t   frame,
  output logic [IDX_W-1:0]   rank
);
  import bpfm_pkg::*;

  logic is_tgt;
  logic older;

  assign is_tgt = (tgt == IDX_W'(POS));
  assign older  = (rank < old_rank);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
      frame.pins  <= '0;
      frame.dirty <= 1'b0;
      rank        <= IDX_W'(POS);
    end else if (cmd.shift) begin
      frame <= nbr_frame;
      rank  <= nbr_rank;
    end else begin
      unique case (cmd.op)
        CELL_NONE: begin
        end
        CELL_HIT: begin
          if (is_tgt) begin
            if (frame.pins != PINS_MAX) frame.pins <= frame.pins + 8'd1;
            rank <= '0;
          end else if (older) begin
            rank <= rank + IDX_W'(1);
          end
        end
        CELL_LOAD: begin
          if (is_tgt) begin
            frame.valid    <= 1'b1;
            frame.file_tag <= cmd.file_tag;
            frame.page_tag <= cmd.page_tag;
            frame.pins     <= 8'd1;
            frame.dirty    <= 1'b0;
            rank           <= '0;
          end else if (older) begin
            rank <= rank + IDX_W'(1);
          end
        end
        CELL_RELEASE: begin
          if (is_tgt) begin
            if (frame.pins != '0) frame.pins <= frame.pins - 8'd1;
            frame.dirty <= frame.dirty | cmd.dirty;
          end
        end
        CELL_CLEAR: begin
          frame.pins  <= '0;
          frame.dirty <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/bpfm_ctrl.sv */
// ----------------------------------------------------------------------------
// Frame manager controller
// Scans the cell ring one frame a cycle, picks hit, empty frame or victim,
// emits results and broadcasts the final update.
// ----------------------------------------------------------------------------
`include "buffer_pool_frame_manager_defines.svh"

module bpfm_ctrl #(
  parameter int FRAMES = bpfm_pkg::FRAMES_DEF,
  localparam int IDX_W = $clog2(FRAMES)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  bpfm_pkg::req_t             req,
  output logic                       result_valid,
  output bpfm_pkg::rsp_t             result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bpfm_pkg::CFG_W-1:0] cfg_data,
  input  bpfm_pkg::frame_t           head,
  input  logic [IDX_W-1:0]           head_rank,
  output bpfm_pkg::cell_cmd_t        cmd,
  output logic [IDX_W-1:0]           tgt,
  output logic [IDX_W-1:0]           old_rank
);
  import bpfm_pkg::*;

  localparam int CMP_W = ($clog2(FRAMES + 1) > CFG_W) ? $clog2(FRAMES + 1) : CFG_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t           state;
  req_t             cur;
  logic [CFG_W-1:0] frames_in_use;
  logic [IDX_W-1:0] cnt;

  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] hit_rank;
  logic             empty_found;
  logic [IDX_W-1:0] empty_idx;
  logic [IDX_W-1:0] empty_rank;
  logic             vic_found;
  logic [IDX_W-1:0] vic_idx;
  logic [IDX_W-1:0] vic_rank;
  logic             vic_wb;
  logic [7:0]       vic_file;
  logic [15:0]      vic_page;

  logic [CMP_W-1:0] fiu_ext;
  logic [CMP_W-1:0] lim;
  logic             in_lim;
  logic             head_hit;
  rsp_t             fin_rsp;
  rsp_t             wb_rsp;
  cell_op_t         fin_op;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = ~busy;

  // Clamp the fill limit into one to FRAMES.
  always_comb begin
    fiu_ext = CMP_W'(frames_in_use);
    if (fiu_ext == '0) begin
      lim = CMP_W'(1);
    end else if (fiu_ext > CMP_W'(FRAMES)) begin
      lim = CMP_W'(FRAMES);
    end else begin
      lim = fiu_ext;
    end
  end

  assign in_lim   = (CMP_W'(cnt) < lim);
  assign head_hit = head.valid && (head.file_tag == cur.file_number)
                    && (head.page_tag == cur.page_number);

  always_comb begin
    wb_rsp                 = '0;
    wb_rsp.status          = ST_WRITEBACK;
    wb_rsp.frame_index     = 4'(cnt);
    wb_rsp.writeback_valid = 1'b1;
    wb_rsp.writeback_file  = head.file_tag;
    wb_rsp.writeback_page  = head.page_tag;
  end

  // Decide the outcome once the ring is aligned again.
  always_comb begin
    fin_rsp      = '0;
    fin_rsp.last = 1'b1;
    fin_op       = CELL_NONE;
    tgt          = hit_idx;
    old_rank     = hit_rank;
    case (cur.opcode)
      OP_GET: begin
        if (hit_found) begin
          fin_op              = CELL_HIT;
          fin_rsp.status      = ST_HIT;
          fin_rsp.frame_index = 4'(hit_idx);
        end else if (empty_found) begin
          fin_op              = CELL_LOAD;
          tgt                 = empty_idx;
          old_rank            = empty_rank;
          fin_rsp.status      = ST_MISS;
          fin_rsp.frame_index = 4'(empty_idx);
        end else if (vic_found) begin
          fin_op                  = CELL_LOAD;
          tgt                     = vic_idx;
          old_rank                = vic_rank;
          fin_rsp.status          = ST_MISS;
          fin_rsp.frame_index     = 4'(vic_idx);
          fin_rsp.writeback_valid = vic_wb;
          fin_rsp.writeback_file  = vic_wb ? vic_file : 8'd0;
          fin_rsp.writeback_page  = vic_wb ? vic_page : 16'd0;
        end else begin
          fin_rsp.status = ST_NO_FRAME;
        end
      end
      OP_RELEASE: begin
        if (hit_found) begin
          fin_op              = CELL_RELEASE;
          fin_rsp.status      = ST_RELEASED;
          fin_rsp.frame_index = 4'(hit_idx);
        end else begin
          fin_rsp.status = ST_NOT_FOUND;
        end
      end
      default: begin
        fin_op         = CELL_CLEAR;
        fin_rsp.status = ST_FLUSH_DONE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.shift    = (state == S_SCAN);
    cmd.op       = (state == S_FINISH) ? fin_op : CELL_NONE;
    cmd.file_tag = cur.file_number;
    cmd.page_tag = cur.page_number;
    cmd.dirty    = cur.mark_dirty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_valid  <= 1'b0;
      frames_in_use <= CFG_RESET;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) frames_in_use <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur         <= req;
            cnt         <= '0;
            hit_found   <= 1'b0;
            empty_found <= 1'b0;
            vic_found   <= 1'b0;
            if (req.opcode == OP_GET || req.opcode == OP_RELEASE
                || req.opcode == OP_FLUSH) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cnt <= cnt + IDX_W'(1);
          if (!hit_found && head_hit) begin
            hit_found <= 1'b1;
            hit_idx   <= cnt;
            hit_rank  <= head_rank;
          end
          if (!empty_found && !head.valid && in_lim) begin
            empty_found <= 1'b1;
            empty_idx   <= cnt;
            empty_rank  <= head_rank;
          end
          if (in_lim && head.pins == '0 && (!vic_found || head_rank > vic_rank)) begin
            vic_found <= 1'b1;
            vic_idx   <= cnt;
            vic_rank  <= head_rank;
            vic_wb    <= head.valid && head.dirty;
            vic_file  <= head.file_tag;
            vic_page  <= head.page_tag;
          end
          if (cur.opcode == OP_FLUSH && head.valid && head.dirty) begin
            result_valid <= 1'b1;
            result       <= wb_rsp;
          end
          if (cnt == IDX_W'(FRAMES - 1)) state <= S_FINISH;
        end
        S_FINISH: begin
          result_valid <= 1'b1;
          result       <= fin_rsp;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BPFM_ASSERT_NOW(a_idle_no_shift, !busy, !cmd.shift, "ring shifted while idle")
  `BPFM_ASSERT_NEXT(a_scan_ends, state == S_SCAN && cnt == IDX_W'(FRAMES - 1),
                    state == S_FINISH, "scan did not end after one pass")
  `BPFM_ASSERT_NEXT(a_finish_reports, state == S_FINISH,
                    result_valid && result.last, "final result missing")
  `BPFM_ASSERT_NOW(a_wb_status, result_valid && result.writeback_valid,
                   result.status == ST_MISS || result.status == ST_WRITEBACK,
                   "write-back on a result that cannot carry one")

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Buffer pool frame manager testbench
// Drives get, release and flush requests into the frame table, keeps its
// own model of frame tags, pins, dirty marks and LRU ranks, and checks every
// strobed result field by field against the predicted sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import bpfm_pkg::*;

  // Opcode outside the defined set; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Cycles to let pass once nothing is expected, scaled to the ring size.
  localparam int SETTLE_CYCLES = 2 * (FRAMES_DEF + 2);
  localparam int PRINT_LIMIT   = 20;
  localparam int EXPECT_DEPTH  = 64;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  req_t                 req;
  logic                 result_valid;
  rsp_t                 result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data;

  // Predicted frame table.
  logic                 pool_valid [FRAMES_DEF];
  logic [7:0]           pool_file  [FRAMES_DEF];
  logic [15:0]          pool_page  [FRAMES_DEF];
  logic [7:0]           pool_pins  [FRAMES_DEF];
  logic                 pool_dirty [FRAMES_DEF];
  logic [3:0]           pool_rank  [FRAMES_DEF];
  logic [CFG_W-1:0]     fill_limit_reg;

  // Ring of expected results, oldest at expect_rd.
  rsp_t                 expected_results [EXPECT_DEPTH];
  logic [5:0]           expect_wr;
  logic [5:0]           expect_rd;
  int                   expect_count;

  int                   mismatch_count;
  int                   requests_accepted;
  int                   flushes_accepted;
  int                   results_checked;
  int                   limit_writes;
  bit                   steady;

  buffer_pool_frame_manager #(
    .FRAMES(FRAMES_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5ms;
    $display("buffer_pool_frame_manager test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Frame table predictor
  // --------------------------------------------------------------------------

  task automatic reset_frame_table();
    for (int g = 0; g < FRAMES_DEF; g++) begin
      pool_valid[g] = 1'b0;
      pool_file[g]  = '0;
      pool_page[g]  = '0;
      pool_pins[g]  = '0;
      pool_dirty[g] = 1'b0;
      pool_rank[g]  = 4'(g);
    end
    fill_limit_reg = CFG_RESET;
  endtask

  function automatic rsp_t make_result(logic [2:0] status, logic [3:0] frame,
                                       logic wb, logic [7:0] wb_file,
                                       logic [15:0] wb_page, logic fin);
    rsp_t r;
    r.status          = status;
    r.frame_index     = frame;
    r.writeback_valid = wb;
    r.writeback_file  = wb_file;
    r.writeback_page  = wb_page;
    r.last            = fin;
    return r;
  endfunction

  // Append one result to the expected sequence.
  task automatic add_expected(rsp_t r);
    expected_results[expect_wr] = r;
    expect_wr = expect_wr + 6'd1;
    expect_count++;
  endtask

  // Make frame f the most recent; shift everything newer than it back one.
  task automatic promote_frame(int f);
    logic [3:0] old;
    old = pool_rank[f];
    for (int g = 0; g < FRAMES_DEF; g++)
      if (pool_rank[g] < old) pool_rank[g] = pool_rank[g] + 4'd1;
    pool_rank[f] = 4'd0;
  endtask

  task automatic predict_frame_request(req_t r);
    int   found;
    int   slot;
    int   lim;
    logic wb;
    found = -1;
    slot  = -1;
    lim   = int'(fill_limit_reg);
    if (lim == 0) lim = 1;
    if (lim > FRAMES_DEF) lim = FRAMES_DEF;
    // Tag search covers every valid frame, whatever the fill limit.
    for (int g = 0; g < FRAMES_DEF; g++)
      if (found < 0 && pool_valid[g] && pool_file[g] == r.file_number &&
          pool_page[g] == r.page_number)
        found = g;
    case (r.opcode)
      OP_GET: begin
        if (found >= 0) begin
          if (pool_pins[found] != PINS_MAX) pool_pins[found] = pool_pins[found] + 8'd1;
          promote_frame(found);
          add_expected(make_result(ST_HIT, 4'(found), 1'b0, 8'd0, 16'd0, 1'b1));
        end else begin
          // Take the lowest empty frame, else the oldest unpinned one.
          for (int g = 0; g < lim; g++)
            if (slot < 0 && !pool_valid[g]) slot = g;
          if (slot < 0)
            for (int g = 0; g < lim; g++)
              if (pool_pins[g] == 0 && (slot < 0 || pool_rank[g] > pool_rank[slot]))
                slot = g;
          if (slot < 0) begin
            add_expected(make_result(ST_NO_FRAME, 4'd0, 1'b0, 8'd0, 16'd0, 1'b1));
          end else begin
            wb = pool_valid[slot] && pool_dirty[slot];
            add_expected(make_result(ST_MISS, 4'(slot), wb,
                                     wb ? pool_file[slot] : 8'd0,
                                     wb ? pool_page[slot] : 16'd0, 1'b1));
            pool_valid[slot] = 1'b1;
            pool_file[slot]  = r.file_number;
            pool_page[slot]  = r.page_number;
            pool_pins[slot]  = 8'd1;
            pool_dirty[slot] = 1'b0;
            promote_frame(slot);
          end
        end
      end
      OP_RELEASE: begin
        if (found < 0) begin
          add_expected(make_result(ST_NOT_FOUND, 4'd0, 1'b0, 8'd0, 16'd0, 1'b1));
        end else begin
          if (pool_pins[found] != 0) pool_pins[found] = pool_pins[found] - 8'd1;
          pool_dirty[found] = pool_dirty[found] | r.mark_dirty;
          add_expected(make_result(ST_RELEASED, 4'(found), 1'b0, 8'd0, 16'd0, 1'b1));
        end
      end
      OP_FLUSH: begin
        // Report dirty frames in ascending order; pages stay resident.
        for (int g = 0; g < FRAMES_DEF; g++) begin
          if (pool_valid[g] && pool_dirty[g])
            add_expected(make_result(ST_WRITEBACK, 4'(g), 1'b1,
                                     pool_file[g], pool_page[g], 1'b0));
          pool_pins[g]  = 8'd0;
          pool_dirty[g] = 1'b0;
        end
        add_expected(make_result(ST_FLUSH_DONE, 4'd0, 1'b0, 8'd0, 16'd0, 1'b1));
      end
      default: begin
        // Drop unknown opcodes: no result, no state change.
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want, int seq);
    if (got !== want)
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                seq, name, got, want));
  endtask

  task automatic check_frame_result(rsp_t got);
    rsp_t want;
    if (expect_count == 0) begin
      report_mismatch($sformatf("unexpected result with status %0d", got.status));
    end else begin
      want = expected_results[expect_rd];
      expect_rd = expect_rd + 6'd1;
      expect_count--;
      check_field("status", 32'(got.status), 32'(want.status), results_checked);
      check_field("frame_index", 32'(got.frame_index), 32'(want.frame_index),
                  results_checked);
      check_field("writeback_valid", 32'(got.writeback_valid),
                  32'(want.writeback_valid), results_checked);
      check_field("writeback_file", 32'(got.writeback_file), 32'(want.writeback_file),
                  results_checked);
      check_field("writeback_page", 32'(got.writeback_page), 32'(want.writeback_page),
                  results_checked);
      check_field("last", 32'(got.last), 32'(want.last), results_checked);
    end
    results_checked++;
  endtask

  // Sample pre-edge values at each edge: check the strobe first, then apply
  // any register write, then predict the request accepted at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) check_frame_result(result);
      if (cfg_valid && cfg_ready) begin
        fill_limit_reg = cfg_data;
        limit_writes++;
      end
      if (start && !busy) begin
        predict_frame_request(req);
        requests_accepted++;
        if (req.opcode == OP_FLUSH) flushes_accepted++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic req_t make_request(logic [1:0] op, logic [7:0] file_no,
                                        logic [15:0] page_no, logic dirty);
    req_t r;
    r.opcode      = op;
    r.file_number = file_no;
    r.page_number = page_no;
    r.mark_dirty  = dirty;
    return r;
  endfunction

  // Present one request and hold it until accepted. Leaves start high so a
  // following request can go out back to back.
  task automatic send_request(req_t item);
    if (!steady && $urandom_range(99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
  endtask

  // Lower start, drain every expected result, then let the ring settle.
  task automatic wait_idle();
    start <= 1'b0;
    while (expect_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_fill_limit(logic [CFG_W-1:0] value);
    wait_idle();
    if (!steady && $urandom_range(99) < 22)
      repeat ($urandom_range(1, 10)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Misses into empty frames, a hit, releases (dirty, at zero pins, not
  // found), an ignored opcode and flushes with and without dirty frames.
  task automatic test_basic_requests();
    send_request(make_request(OP_GET, 8'h00, 16'h0000, 1'b0));
    send_request(make_request(OP_GET, 8'hFF, 16'hFFFF, 1'b1));
    send_request(make_request(OP_GET, 8'h00, 16'h0000, 1'b1));
    send_request(make_request(OP_GET, 8'h5A, 16'hA5A5, 1'b0));
    send_request(make_request(OP_RELEASE, 8'hFF, 16'hFFFF, 1'b1));
    send_request(make_request(OP_RELEASE, 8'hFF, 16'hFFFF, 1'b0));
    send_request(make_request(OP_RELEASE, 8'h03, 16'h0003, 1'b1));
    send_request(make_request(OP_UNUSED, 8'hFF, 16'hFFFF, 1'b1));
    send_request(make_request(OP_FLUSH, 8'hFF, 16'hFFFF, 1'b1));
    send_request(make_request(OP_FLUSH, 8'h00, 16'h0000, 1'b0));
    send_request(make_request(OP_RELEASE, 8'h00, 16'h0000, 1'b0));
    wait_idle();
  endtask

  // LRU eviction inside a small fill limit, a dirty victim, no frame free,
  // and hits and releases on a frame above the limit.
  task automatic test_eviction_and_scope();
    write_fill_limit(5'd2);
    send_request(make_request(OP_GET, 8'h00, 16'h0000, 1'b0));
    send_request(make_request(OP_RELEASE, 8'h00, 16'h0000, 1'b1));
    send_request(make_request(OP_GET, 8'h07, 16'h0007, 1'b0));
    send_request(make_request(OP_GET, 8'h09, 16'h0009, 1'b0));
    send_request(make_request(OP_GET, 8'h0B, 16'h000B, 1'b0));
    send_request(make_request(OP_GET, 8'h5A, 16'hA5A5, 1'b0));
    send_request(make_request(OP_RELEASE, 8'h5A, 16'hA5A5, 1'b1));
    send_request(make_request(OP_FLUSH, 8'h00, 16'h0000, 1'b0));
    wait_idle();
  endtask

  // Zero acts as one frame; an over-range limit acts as the full pool, which
  // lets a flush produce its longest sequence.
  task automatic test_limit_extremes();
    write_fill_limit(5'd0);
    send_request(make_request(OP_GET, 8'h20, 16'h0100, 1'b0));
    send_request(make_request(OP_GET, 8'h21, 16'h0101, 1'b0));
    send_request(make_request(OP_RELEASE, 8'h20, 16'h0100, 1'b1));
    send_request(make_request(OP_GET, 8'h21, 16'h0101, 1'b0));
    write_fill_limit(5'd31);
    for (int i = 0; i < FRAMES_DEF; i++) begin
      send_request(make_request(OP_GET, 8'(8'h40 + i), 16'(i * 4099), 1'b0));
      send_request(make_request(OP_RELEASE, 8'(8'h40 + i), 16'(i * 4099), 1'b1));
    end
    send_request(make_request(OP_FLUSH, 8'h00, 16'h0000, 1'b0));
    send_request(make_request(OP_FLUSH, 8'h00, 16'h0000, 1'b0));
    wait_idle();
  endtask

  // Mostly gets and releases on a small page working set, so hits, pins and
  // evictions interact; a few flushes, ignored opcodes and stray pages.
  task automatic test_random_traffic(int count, logic [CFG_W-1:0] limit, bit no_idle);
    logic [7:0]  set_file [20];
    logic [15:0] set_page [20];
    req_t        item;
    int          sent;
    int          roll;
    int          pick;
    write_fill_limit(limit);
    steady = no_idle;
    for (int i = 0; i < 20; i++) begin
      set_file[i] = 8'($urandom);
      set_page[i] = 16'($urandom);
    end
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      pick = ($urandom_range(1) == 1) ? $urandom_range(7) : $urandom_range(19);
      item = make_request(OP_GET, set_file[pick], set_page[pick], 1'($urandom));
      if (roll < 44) begin
        item.opcode = OP_GET;
      end else if (roll < 82) begin
        item.opcode = OP_RELEASE;
      end else if (roll < 88) begin
        item.opcode = OP_FLUSH;
      end else if (roll < 93) begin
        item = make_request(OP_UNUSED, 8'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        item = make_request(2'($urandom_range(1)), 8'($urandom), 16'($urandom),
                            1'($urandom));
      end
      send_request(item);
      if (item.opcode != OP_UNUSED) sent++;
    end
    steady = 1'b0;
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Run
  // --------------------------------------------------------------------------

  initial begin
    rst               = 1'b1;
    start             = 1'b0;
    req               = '0;
    cfg_valid         = 1'b0;
    cfg_data          = '0;
    mismatch_count    = 0;
    requests_accepted = 0;
    flushes_accepted  = 0;
    results_checked   = 0;
    limit_writes      = 0;
    steady            = 1'b0;
    expect_wr         = '0;
    expect_rd         = '0;
    expect_count      = 0;
    reset_frame_table();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_requests();
    test_eviction_and_scope();
    test_limit_extremes();
    test_random_traffic(23, 5'd16, 1'b1);
    test_random_traffic(23, 5'd5, 1'b0);
    test_random_traffic(23, 5'd1, 1'b0);
    test_random_traffic(23, 5'd31, 1'b0);
    test_random_traffic(23, 5'd0, 1'b0);
    test_random_traffic(23, 5'($urandom_range(2, 15)), 1'b0);
    wait_idle();

    $display("Covered %0d requests (%0d flushes) over %0d fill-limit settings,",
             requests_accepted, flushes_accepted, limit_writes);
    $display("checked %0d results, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("buffer_pool_frame_manager test passed");
    end else begin
      $display("buffer_pool_frame_manager test failed");
    end
    $finish;
  end

endmodule
